// File: hw/rtl/ptx_pkg.sv
// ----------------------------------------------------------------------------
// ptx_pkg
// Shared widths, item kinds and types for the 4x4 point transform pipeline.
// ----------------------------------------------------------------------------
package ptx_pkg;

  // Fixed-point format of coefficients, points and results
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned PROD_W    = 2 * COEF_W;
  localparam int unsigned PAIR_W    = PROD_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 2;

  // Matrix geometry
  localparam int unsigned DIM       = 4;
  localparam int unsigned IDX_W     = 2;

  // Input stream packing (tdata, lowest bit first)
  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = DIM * COEF_W;

  // Item kinds carried on tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  // Identity diagonal value, 1.0 in fixed point
  localparam logic signed [COEF_W-1:0] ONE_Q = COEF_W'(1) << FRAC_BITS;

  // Saturation limits
  localparam logic signed [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

// File: hw/rtl/ptx_mul_stage.sv
// ----------------------------------------------------------------------------
// ptx_mul_stage
// Matrix store plus the sixteen coefficient-by-component multipliers.
// Load items update the store; transform items register all products.
// ----------------------------------------------------------------------------
module ptx_mul_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [ptx_pkg::IDX_W-1:0]       coef_row_i,
  input  logic [ptx_pkg::IDX_W-1:0]       coef_col_i,
  input  ptx_pkg::coef_t                  coef_value_i,
  input  ptx_pkg::coef_t                  pt_i   [ptx_pkg::DIM],
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ptx_pkg::prod_t                  prod_o [ptx_pkg::DIM*ptx_pkg::DIM]
);

  ptx_pkg::coef_t mat_q  [ptx_pkg::DIM][ptx_pkg::DIM];
  ptx_pkg::prod_t prod_d [ptx_pkg::DIM*ptx_pkg::DIM];
  ptx_pkg::prod_t prod_q [ptx_pkg::DIM*ptx_pkg::DIM];
  logic           valid_q;
  logic           xfer;
  logic           load_en;
  logic           take_en;

  assign in_ready_o = !valid_q || out_ready_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign load_en    = xfer && (kind_i == ptx_pkg::KIND_LOAD);
  assign take_en    = xfer && (kind_i == ptx_pkg::KIND_XFORM);

  // Write one coefficient per load transfer; reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ptx_pkg::DIM; r++) begin
        for (int c = 0; c < ptx_pkg::DIM; c++) begin
          mat_q[r][c] <= (r == c) ? ptx_pkg::ONE_Q : '0;
        end
      end
    end else if (load_en) begin
      mat_q[coef_row_i][coef_col_i] <= coef_value_i;
    end
  end

  // Form all sixteen full-width products against the current matrix
  always_comb begin
    for (int r = 0; r < ptx_pkg::DIM; r++) begin
      for (int c = 0; c < ptx_pkg::DIM; c++) begin
        prod_d[r*ptx_pkg::DIM + c] = ptx_pkg::PROD_W'(mat_q[r][c])
                                   * ptx_pkg::PROD_W'(pt_i[c]);
      end
    end
  end

  // Stage valid: set on a transform transfer, drop once taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= take_en;
    end
  end

  // Product registers
  always_ff @(posedge clk_i) begin
    if (take_en) begin
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = valid_q;
  assign prod_o      = prod_q;

`ifndef SYNTHESIS
  // A load transfer lands in the addressed matrix entry
  a_load_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en |=> mat_q[$past(coef_row_i)][$past(coef_col_i)] == $past(coef_value_i))
    else $error("matrix entry not updated by load");
`endif

endmodule

// File: hw/rtl/ptx_add_tree.sv
// ----------------------------------------------------------------------------
// ptx_add_tree
// Two registered adder levels reducing each row's four products to one sum.
// ----------------------------------------------------------------------------
module ptx_add_tree (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ptx_pkg::prod_t prod_i [ptx_pkg::DIM*ptx_pkg::DIM],
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ptx_pkg::sum_t  sum_o  [ptx_pkg::DIM]
);

  ptx_pkg::pair_t pair_q [ptx_pkg::DIM*2];
  ptx_pkg::sum_t  sum_q  [ptx_pkg::DIM];
  logic           pair_valid_q;
  logic           sum_valid_q;
  logic           pair_ready;
  logic           sum_ready;

  assign sum_ready  = !sum_valid_q || out_ready_i;
  assign pair_ready = !pair_valid_q || sum_ready;
  assign in_ready_o = pair_ready;

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
    end else begin
      if (pair_ready) begin
        pair_valid_q <= in_valid_i;
      end
      if (sum_ready) begin
        sum_valid_q <= pair_valid_q;
      end
    end
  end

  // First level: add neighboring products
  always_ff @(posedge clk_i) begin
    if (pair_ready && in_valid_i) begin
      for (int i = 0; i < ptx_pkg::DIM*2; i++) begin
        pair_q[i] <= ptx_pkg::PAIR_W'(prod_i[2*i]) + ptx_pkg::PAIR_W'(prod_i[2*i+1]);
      end
    end
  end

  // Second level: add the two pair sums of each row
  always_ff @(posedge clk_i) begin
    if (sum_ready && pair_valid_q) begin
      for (int r = 0; r < ptx_pkg::DIM; r++) begin
        sum_q[r] <= ptx_pkg::SUM_W'(pair_q[2*r]) + ptx_pkg::SUM_W'(pair_q[2*r+1]);
      end
    end
  end

  assign out_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

`ifndef SYNTHESIS
  // A sum only appears from a pair stage that held data or by holding itself
  a_sum_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sum_valid_q) |-> $past(pair_valid_q))
    else $error("sum stage valid without pair stage data");

  // A stalled sum stage keeps its valid
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid_q && !out_ready_i |=> sum_valid_q)
    else $error("stalled sum stage dropped its item");
`endif

endmodule

// File: hw/rtl/ptx_sat_stage.sv
// ----------------------------------------------------------------------------
// ptx_sat_stage
// Shift each row sum down by the fraction width, clamp to 32 bits and hold
// the result in the output register.
// ----------------------------------------------------------------------------
module ptx_sat_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ptx_pkg::sum_t  sum_i [ptx_pkg::DIM],
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ptx_pkg::coef_t res_o [ptx_pkg::DIM]
);

  localparam int unsigned HI_W = ptx_pkg::SUM_W - ptx_pkg::COEF_W + 1;

  ptx_pkg::sum_t  shifted [ptx_pkg::DIM];
  ptx_pkg::coef_t res_d   [ptx_pkg::DIM];
  ptx_pkg::coef_t res_q   [ptx_pkg::DIM];
  logic [HI_W-1:0] hi_bits [ptx_pkg::DIM];
  logic           valid_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // Arithmetic shift, then clamp when the upper bits are not a sign run
  always_comb begin
    for (int r = 0; r < ptx_pkg::DIM; r++) begin
      shifted[r] = sum_i[r] >>> ptx_pkg::FRAC_BITS;
      hi_bits[r] = shifted[r][ptx_pkg::SUM_W-1:ptx_pkg::COEF_W-1];
      if ((&hi_bits[r]) || !(|hi_bits[r])) begin
        res_d[r] = shifted[r][ptx_pkg::COEF_W-1:0];
      end else if (sum_i[r][ptx_pkg::SUM_W-1]) begin
        res_d[r] = ptx_pkg::SAT_MIN;
      end else begin
        res_d[r] = ptx_pkg::SAT_MAX;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Output data register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/point_transform_4x4.sv
// ----------------------------------------------------------------------------
// point_transform_4x4
// Homogeneous 4x4 matrix-times-point transform in signed Q16.16.
// ----------------------------------------------------------------------------
// The block holds a 4x4 matrix (identity after reset). A transfer with tuser
// low loads one coefficient at (row, col) and yields no result; a transfer
// with tuser high carries a point and yields the matrix-times-point product,
// each component the exact sum of four 64-bit products shifted right by 16
// and clamped to signed 32 bits. One item is accepted every clock unless the
// output stalls; a point passes through the product registers of sixteen
// parallel 32x32 multipliers, two adder levels and the clamp/output
// register. A load takes effect for the very next point accepted.
// ----------------------------------------------------------------------------
module point_transform_4x4 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] coef_row, [3:2] coef_col, [35:4] coef_value, [67:36] pt_x,
  // [99:68] pt_y, [131:100] pt_z, [163:132] pt_w, [167:164] zero
  input  logic [ptx_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] kind
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
  output logic [ptx_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned PT_LSB = 2*ptx_pkg::IDX_W + ptx_pkg::COEF_W;

  logic [ptx_pkg::IDX_W-1:0] coef_row;
  logic [ptx_pkg::IDX_W-1:0] coef_col;
  ptx_pkg::coef_t            coef_value;
  ptx_pkg::coef_t            pt    [ptx_pkg::DIM];
  ptx_pkg::prod_t            prod  [ptx_pkg::DIM*ptx_pkg::DIM];
  ptx_pkg::sum_t             sum   [ptx_pkg::DIM];
  ptx_pkg::coef_t            res   [ptx_pkg::DIM];
  logic                      mul_valid;
  logic                      mul_ready;
  logic                      add_valid;
  logic                      add_ready;

  // Unpack the input transfer
  assign coef_row   = s_axis_tdata[ptx_pkg::IDX_W-1:0];
  assign coef_col   = s_axis_tdata[2*ptx_pkg::IDX_W-1:ptx_pkg::IDX_W];
  assign coef_value = s_axis_tdata[2*ptx_pkg::IDX_W +: ptx_pkg::COEF_W];

  always_comb begin
    for (int c = 0; c < ptx_pkg::DIM; c++) begin
      pt[c] = s_axis_tdata[PT_LSB + c*ptx_pkg::COEF_W +: ptx_pkg::COEF_W];
    end
  end

  ptx_mul_stage u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .kind_i       (s_axis_tuser),
    .coef_row_i   (coef_row),
    .coef_col_i   (coef_col),
    .coef_value_i (coef_value),
    .pt_i         (pt),
    .out_valid_o  (mul_valid),
    .out_ready_i  (mul_ready),
    .prod_o       (prod)
  );

  ptx_add_tree u_add (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .prod_i      (prod),
    .out_valid_o (add_valid),
    .out_ready_i (add_ready),
    .sum_o       (sum)
  );

  ptx_sat_stage u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (add_valid),
    .in_ready_o  (add_ready),
    .sum_i       (sum),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result transfer
  always_comb begin
    for (int r = 0; r < ptx_pkg::DIM; r++) begin
      m_axis_tdata[r*ptx_pkg::COEF_W +: ptx_pkg::COEF_W] = res[r];
    end
  end

`ifndef SYNTHESIS
  // With nothing waiting at the output, the whole pipeline can move
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register is empty");
`endif

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for the 4x4 point transform.
// ----------------------------------------------------------------------------
// A queue of coefficient loads and point transforms is driven into the slave
// stream. Source gaps and sink stalls come in short random bursts. A local
// copy of the matrix is updated on every accepted load. Each accepted point
// is transformed in 66-bit signed arithmetic, shifted and clamped, and the
// expected result is queued. Every result transfer is checked field by field
// against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ptx_pkg::coef_t w;
    ptx_pkg::coef_t z;
    ptx_pkg::coef_t y;
    ptx_pkg::coef_t x;
  } point_t;

  typedef struct {
    logic           kind;
    logic [1:0]     row;
    logic [1:0]     col;
    ptx_pkg::coef_t value;
    point_t         pt;
  } ptx_item_t;

  // Quiet tail: no gaps or stalls over the last items
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned RANDOM_ITEMS = 1680;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [ptx_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                           s_axis_tuser  = ptx_pkg::KIND_LOAD;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [ptx_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  ptx_item_t      pending_items [$];
  point_t         xformed_q [$];
  ptx_pkg::coef_t coef_store [16];
  ptx_item_t      drive_item;
  point_t         got_pt;
  point_t         want_pt;
  int unsigned    sent_count  = 0;
  int unsigned    total_items = 0;
  int unsigned    src_gap     = 0;
  int unsigned    snk_stall   = 0;
  int unsigned    error_count = 0;

  point_transform_4x4 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Idle bursts run in three of every four blocks of items, never in the tail
  function automatic bit idling_allowed();
    return (sent_count + TAIL_ITEMS < total_items) && (((sent_count / 128) % 4) != 3);
  endfunction

  // Mix of magnitudes so that both the clamp and the exact path get traffic
  function automatic ptx_pkg::coef_t rand_q();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: return ptx_pkg::coef_t'(v);
      1: begin
        case (v[2:0])
          3'd0: return ptx_pkg::SAT_MAX;
          3'd1: return ptx_pkg::SAT_MIN;
          3'd2: return '0;
          3'd3: return '1;
          3'd4: return ptx_pkg::ONE_Q;
          default: return -ptx_pkg::ONE_Q;
        endcase
      end
      2, 3: return ptx_pkg::coef_t'({{13{v[18]}}, v[18:0]});
      default: return ptx_pkg::coef_t'({{8{v[23]}}, v[23:0]});
    endcase
  endfunction

  // Unused fields carry random content so that they are proven ignored
  function automatic ptx_item_t load_item(logic [1:0] row, logic [1:0] col,
                                          ptx_pkg::coef_t value);
    ptx_item_t it;
    it.kind  = ptx_pkg::KIND_LOAD;
    it.row   = row;
    it.col   = col;
    it.value = value;
    it.pt    = {$urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  function automatic ptx_item_t xform_item(ptx_pkg::coef_t x, ptx_pkg::coef_t y,
                                           ptx_pkg::coef_t z, ptx_pkg::coef_t w);
    ptx_item_t it;
    it.kind  = ptx_pkg::KIND_XFORM;
    it.row   = 2'($urandom);
    it.col   = 2'($urandom);
    it.value = ptx_pkg::coef_t'($urandom);
    it.pt    = '{w: w, z: z, y: y, x: x};
    return it;
  endfunction

  // One component: exact 66-bit sum of four products, floor shift, clamp
  function automatic ptx_pkg::coef_t row_dot(int unsigned row, point_t p);
    ptx_pkg::coef_t comp [4];
    ptx_pkg::prod_t prod;
    ptx_pkg::sum_t  acc;
    ptx_pkg::sum_t  shifted;
    comp = '{p.x, p.y, p.z, p.w};
    acc  = '0;
    for (int k = 0; k < 4; k++) begin
      prod = ptx_pkg::prod_t'(coef_store[row * 4 + k]) * ptx_pkg::prod_t'(comp[k]);
      acc  = acc + ptx_pkg::sum_t'(prod);
    end
    shifted = acc >>> ptx_pkg::FRAC_BITS;
    if (shifted > ptx_pkg::sum_t'(ptx_pkg::SAT_MAX)) return ptx_pkg::SAT_MAX;
    if (shifted < ptx_pkg::sum_t'(ptx_pkg::SAT_MIN)) return ptx_pkg::SAT_MIN;
    return ptx_pkg::coef_t'(shifted);
  endfunction

  function automatic point_t transform_point(point_t p);
    point_t r;
    r.x = row_dot(0, p);
    r.y = row_dot(1, p);
    r.z = row_dot(2, p);
    r.w = row_dot(3, p);
    return r;
  endfunction

  task automatic check_field(string name, ptx_pkg::coef_t want, ptx_pkg::coef_t got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Source: present the next item once the previous one has moved
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
        src_gap = $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drive_item = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drive_item.kind;
        s_axis_tdata  <= {4'b0, drive_item.pt.w, drive_item.pt.z, drive_item.pt.y,
                          drive_item.pt.x, drive_item.value, drive_item.col, drive_item.row};
        sent_count++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: stall in short bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (snk_stall > 0) begin
      snk_stall--;
      m_axis_tready <= 1'b0;
    end else if (idling_allowed() && $urandom_range(0, 3) == 0) begin
      snk_stall = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Track loads, predict points, then check result transfers in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ptx_pkg::KIND_LOAD) begin
          coef_store[{s_axis_tdata[1:0], s_axis_tdata[3:2]}] =
            ptx_pkg::coef_t'(s_axis_tdata[35:4]);
        end else begin
          xformed_q.push_back(transform_point(point_t'(s_axis_tdata[163:36])));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_pt = point_t'(m_axis_tdata);
        if (xformed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want_pt = xformed_q.pop_front();
          check_field("out_x", want_pt.x, got_pt.x);
          check_field("out_y", want_pt.y, got_pt.y);
          check_field("out_z", want_pt.z, got_pt.z);
          check_field("out_w", want_pt.w, got_pt.w);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      coef_store[i] = (i % 5 == 0) ? ptx_pkg::ONE_Q : ptx_pkg::coef_t'(0);
    end

    // Identity matrix passes extreme points through unchanged
    pending_items.push_back(xform_item(ptx_pkg::SAT_MAX, ptx_pkg::SAT_MIN, '0, '1));
    // Row 0 at the positive extreme, row 1 at the negative extreme
    for (int c = 0; c < 4; c++) begin
      pending_items.push_back(load_item(2'd0, 2'(c), ptx_pkg::SAT_MAX));
      pending_items.push_back(load_item(2'd1, 2'(c), ptx_pkg::SAT_MIN));
    end
    // Row 2 holds tiny terms to show the floor shift, row 3 loses its one
    pending_items.push_back(load_item(2'd2, 2'd0, ptx_pkg::coef_t'(1)));
    pending_items.push_back(load_item(2'd2, 2'd1, '1));
    pending_items.push_back(load_item(2'd3, 2'd3, '0));
    // Clamp high and low, and a sum that needs the full wide adder
    pending_items.push_back(xform_item(ptx_pkg::SAT_MAX, ptx_pkg::SAT_MAX,
                                       ptx_pkg::SAT_MAX, ptx_pkg::SAT_MAX));
    pending_items.push_back(xform_item(ptx_pkg::SAT_MIN, ptx_pkg::SAT_MIN,
                                       ptx_pkg::SAT_MIN, ptx_pkg::SAT_MIN));
    pending_items.push_back(xform_item(ptx_pkg::SAT_MAX, ptx_pkg::SAT_MIN,
                                       ptx_pkg::SAT_MAX, ptx_pkg::SAT_MIN));
    pending_items.push_back(xform_item('1, '0, '0, '0));
    pending_items.push_back(xform_item(ptx_pkg::coef_t'(1), ptx_pkg::coef_t'(1), '0, '0));
    pending_items.push_back(xform_item('0, '0, '0, '0));

    // Random mix: mostly points, with loads scattered over the whole matrix
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_items.push_back(load_item(2'($urandom), 2'($urandom), rand_q()));
      end else begin
        pending_items.push_back(xform_item(rand_q(), rand_q(), rand_q(), rand_q()));
      end
    end
    total_items = pending_items.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain stimulus, then expectations, then watch for stray results
    while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (xformed_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
